// ===== rtl/core/npc_pkg.sv =====
// shared constants, token type and state codes for the nearest palette color unit
// no dependencies
package npc_pkg;

    localparam int CH_W           = 8;
    localparam int SLOT_W         = 8;
    localparam int COLOR_W        = 8;
    localparam int CFG_W          = 9;
    localparam int SQ_W           = 2 * CH_W;
    localparam int DIST_W         = SQ_W + 2;
    localparam int MAX_COLORS_DEF = 256;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // query token that walks down the cell chain
    typedef struct packed {
        logic              valid;
        logic              have;
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [DIST_W-1:0] best_sq;
    } token_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SEARCH
    } state_t;

endpackage

// ===== rtl/core/npc_cell.sv =====
// one palette cell: holds a single entry and updates the passing query token
// depends on npc_pkg
module npc_cell #(
    parameter int IDX_W    = 8,
    parameter int CELL_IDX = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         wr_en,
    input  logic [npc_pkg::CH_W-1:0]     wr_red,
    input  logic [npc_pkg::CH_W-1:0]     wr_green,
    input  logic [npc_pkg::CH_W-1:0]     wr_blue,
    input  logic                         active,
    input  npc_pkg::token_t              tok_in,
    input  logic [IDX_W-1:0]             idx_in,
    output npc_pkg::token_t              tok_out,
    output logic [IDX_W-1:0]             idx_out
);

    logic [npc_pkg::CH_W-1:0]   red_reg;
    logic [npc_pkg::CH_W-1:0]   green_reg;
    logic [npc_pkg::CH_W-1:0]   blue_reg;
    logic                       valid_reg;
    logic                       valid_next;
    npc_pkg::token_t            tok_reg;
    npc_pkg::token_t            tok_next;
    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           idx_next;
    logic [npc_pkg::DIST_W-1:0] cand_sq;
    logic                       take;

    function automatic logic [npc_pkg::SQ_W-1:0] chan_sq(
        input logic [npc_pkg::CH_W-1:0] a,
        input logic [npc_pkg::CH_W-1:0] b
    );
        logic [npc_pkg::CH_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return npc_pkg::SQ_W'(d) * npc_pkg::SQ_W'(d);
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            red_reg   <= wr_red;
            green_reg <= wr_green;
            blue_reg  <= wr_blue;
        end
    end

    always_comb
    begin
        cand_sq = npc_pkg::DIST_W'(chan_sq(tok_in.red, red_reg))
                + npc_pkg::DIST_W'(chan_sq(tok_in.green, green_reg))
                + npc_pkg::DIST_W'(chan_sq(tok_in.blue, blue_reg));
        // strict less-than keeps the lowest index on ties
        take = active && (!tok_in.have || (cand_sq < tok_in.best_sq));

        valid_next = tok_in.valid;
        tok_next   = tok_in;
        idx_next   = idx_in;
        if (take)
        begin
            tok_next.have    = 1'b1;
            tok_next.best_sq = cand_sq;
            idx_next         = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tok_reg <= tok_next;
            idx_reg <= idx_next;
        end
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = valid_reg;
    end

    assign idx_out = idx_reg;

endmodule

// ===== rtl/core/nearest_palette_color_unit.sv =====
// top level of the nearest palette color unit: handshake control and the cell chain
// depends on npc_pkg and npc_cell
//
// Finds the palette entry nearest to a pixel by squared euclidean rgb distance.
// The palette lives in a chain of MAX_COLORS cells, one entry per cell. A write
// word (func 0) loads the cell named by entry_index and gives no result; slots
// at or above MAX_COLORS are dropped. A query word (func 1) enters the head of
// the chain and moves one cell per cycle while the chain is not frozen; each cell
// below palette_size compares its entry with the pixel and takes over the running
// best when strictly closer, so ties go to the lowest index. A query always walks
// the whole chain, whatever palette_size is, and its answer is registered into
// the result register as it leaves the tail; no next word is taken before that.
// Writes go at one per cycle while no query is in flight, even with a result
// still waiting. An empty palette answers index 0. Entries read by a query must
// have been written first. The chain freezes if its result is ready while the
// result register is still held by a stall. palette_size is written through the
// cfg port, which is always ready; the user must write it only while the unit
// is idle, and the block itself does not enforce this.
module nearest_palette_color_unit #(
    parameter int MAX_COLORS = npc_pkg::MAX_COLORS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [npc_pkg::CFG_W-1:0]    palette_size,
    // item channel
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         func,
    input  logic [npc_pkg::SLOT_W-1:0]   entry_index,
    input  logic [npc_pkg::CH_W-1:0]     red,
    input  logic [npc_pkg::CH_W-1:0]     green,
    input  logic [npc_pkg::CH_W-1:0]     blue,
    // result channel
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [npc_pkg::COLOR_W-1:0]  color_index
);

    localparam int IDX_W = $clog2(MAX_COLORS);
    // compare width wide enough for the cell index, the slot and the size register
    localparam int CMP_W = (IDX_W + 1 > npc_pkg::CFG_W) ? IDX_W + 1 : npc_pkg::CFG_W;

    npc_pkg::state_t             state_reg;
    npc_pkg::state_t             state_next;
    logic [npc_pkg::CFG_W-1:0]   size_reg;
    logic                        res_valid_reg;
    logic                        res_valid_next;
    logic [npc_pkg::COLOR_W-1:0] res_index_reg;
    logic [npc_pkg::COLOR_W-1:0] res_index_next;

    logic                        item_acc;
    logic                        query_acc;
    logic                        write_acc;
    logic                        chain_adv;
    logic                        tail_done;

    npc_pkg::token_t             tok [0:MAX_COLORS];
    logic [IDX_W-1:0]            idx [0:MAX_COLORS];

    // config register, port always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_reg <= palette_size;
        end
    end

    // item handshake
    assign item_stall = (state_reg != npc_pkg::ST_IDLE);
    assign item_acc   = item_valid && !item_stall;
    assign query_acc  = item_acc && (func == npc_pkg::FUNC_QUERY);
    assign write_acc  = item_acc && (func == npc_pkg::FUNC_WRITE);

    // chain holds only when its finished word cannot move into the result register
    assign chain_adv = !(tok[MAX_COLORS].valid && res_valid_reg && result_stall);
    assign tail_done = tok[MAX_COLORS].valid && chain_adv;

    // head token: fresh query with no best yet
    always_comb
    begin
        tok[0].valid   = query_acc;
        tok[0].have    = 1'b0;
        tok[0].red     = red;
        tok[0].green   = green;
        tok[0].blue    = blue;
        tok[0].best_sq = '0;
        idx[0]         = '0;
    end

    // cell chain, one palette entry per cell
    for (genvar i = 0; i < MAX_COLORS; i++)
    begin : g_cell
        logic cell_wr;
        logic cell_active;

        assign cell_wr     = write_acc && (CMP_W'(entry_index) == CMP_W'(i));
        assign cell_active = (CMP_W'(size_reg) > CMP_W'(i));

        npc_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (chain_adv),
            .wr_en    (cell_wr),
            .wr_red   (red),
            .wr_green (green),
            .wr_blue  (blue),
            .active   (cell_active),
            .tok_in   (tok[i]),
            .idx_in   (idx[i]),
            .tok_out  (tok[i+1]),
            .idx_out  (idx[i+1])
        );
    end

    // control state: one query in flight at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= npc_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_index_reg <= res_index_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        res_index_next = res_index_reg;

        // result register drains, then may refill from the chain tail
        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (tail_done)
        begin
            res_valid_next = 1'b1;
            res_index_next = npc_pkg::COLOR_W'(idx[MAX_COLORS]);
        end

        unique case (state_reg)
            npc_pkg::ST_IDLE:
            begin
                if (query_acc)
                begin
                    state_next = npc_pkg::ST_SEARCH;
                end
            end
            npc_pkg::ST_SEARCH:
            begin
                if (tail_done)
                begin
                    state_next = npc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = npc_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = res_valid_reg;
    assign color_index  = res_index_reg;

endmodule

// ===== rtl/core/npc_checker.sv =====
// port-level checks for the nearest palette color unit, bound to the top level
// depends on npc_pkg and nearest_palette_color_unit
module npc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_stall,
    input logic                         func,
    input logic                         result_valid,
    input logic                         result_stall
);

    // a taken query blocks the item channel until its answer is out
    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && (func == npc_pkg::FUNC_QUERY)) |=> item_stall)
        else $error("item channel open right after a query word");

    // a write word never produces a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && (func == npc_pkg::FUNC_WRITE) && !result_valid)
        |=> !result_valid)
        else $error("result word appeared after a write word");

    // a new result only comes out of a query in flight
    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result word without a query in flight");

    // a stalled result word stays offered
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("result word dropped under stall");

endmodule

bind nearest_palette_color_unit npc_checker u_npc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .result_valid (result_valid),
    .result_stall (result_stall)
);
